[hdl/bfa_pkg.sv]
// Shared types, constants and helpers for the bitmap frame allocator.
// Used by bfa_map and bitmap_frame_allocator; depends on nothing.
package bfa_pkg;

  localparam int MAX_FRAMES   = 4096;
  localparam int WORD_BITS    = 64;
  localparam int MAP_WORDS    = MAX_FRAMES / WORD_BITS;
  localparam int FRAME_W      = 12;
  localparam int COUNT_W      = 13;
  localparam int WORD_IDX_W   = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W    = $clog2(WORD_BITS);
  localparam int GROUP_BITS   = 8;
  localparam int GROUPS       = WORD_BITS / GROUP_BITS;
  localparam int GROUP_IDX_W  = $clog2(GROUPS);
  localparam int OFFSET_W     = $clog2(GROUP_BITS);
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = COUNT_W'(4096);
  localparam logic [COUNT_W-1:0] FRAME_LIMIT_MAX   = COUNT_W'(MAX_FRAMES);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NONE_FREE = 2'd1;
  localparam logic [1:0] STATUS_RANGE     = 2'd2;

  localparam logic REG_FRAME_COUNT = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MODIFY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [FRAME_W-1:0] frame_number;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number_out;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic                  en;
    logic [WORD_IDX_W-1:0] addr;
    logic [WORD_BITS-1:0]  data;
  } map_wr_t;

  function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [GROUPS-1:0]      grp_any;
    logic [GROUP_IDX_W-1:0] g;
    logic [GROUP_BITS-1:0]  sel;
    logic [OFFSET_W-1:0]    b;
    grp_any = '0;
    for (int i = 0; i < GROUPS; i++) begin
      grp_any[i] = |w[i*GROUP_BITS +: GROUP_BITS];
    end
    g = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (grp_any[i]) begin
        g = GROUP_IDX_W'(i);
      end
    end
    sel = w[g*GROUP_BITS +: GROUP_BITS];
    b = '0;
    for (int i = GROUP_BITS - 1; i >= 0; i--) begin
      if (sel[i]) begin
        b = OFFSET_W'(i);
      end
    end
    return {g, b};
  endfunction

endpackage

[hdl/bfa_map.sv]
// Free-frame map storage: one synchronous word memory with a registered read.
// Per-word valid bits make unwritten words read as all free. Uses bfa_pkg.
module bfa_map (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [bfa_pkg::WORD_IDX_W-1:0]      raddr,
  output logic [bfa_pkg::WORD_BITS-1:0]       rdata,
  input  bfa_pkg::map_wr_t                    wr
);

  logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::MAP_WORDS];
  logic [bfa_pkg::MAP_WORDS-1:0] written;
  logic [bfa_pkg::WORD_BITS-1:0] rd_word;
  logic                          rd_written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_word <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      rd_written <= written[raddr];
    end
  end

  assign rdata = rd_written ? rd_word : '1;

endmodule

[hdl/bitmap_frame_allocator.sv]
// Bitmap page-frame allocator, first fit, top level.
// Depends on bfa_pkg and bfa_map.
//
// Usage: requests arrive on req (valid/ready), one result beat per request
// leaves on rsp (valid/ready). Allocate scans the free map from word 0 up to
// the active limit, one 64-frame word per cycle out of the map memory, and
// claims the lowest free frame. Free and reserve read the word holding the
// frame, modify one bit and write it back.
// Range errors and allocate with a zero limit go from the request beat straight
// to the result register; free and reserve pass through the modify state, and
// allocate through the scan state, which checks 1 to 64 words. One request is
// in flight at a time; the next one is taken the cycle after the previous
// result is loaded into the output register.
// A stalled receiver holds the result beat in the output register; the block
// then accepts one more request and holds its result until the beat leaves.
// frame_count (APB port, offset 0, reset value 4096) must be written by the
// user only while the block is idle; the block does not enforce this. Reset
// marks every frame free at once (no clearing pass), empties the output register.
module bitmap_frame_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bfa_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output bfa_pkg::rsp_t                 rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [bfa_pkg::PDATA_W-1:0]   pwdata,
  output logic [bfa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int WIW = bfa_pkg::WORD_IDX_W;
  localparam int BIW = bfa_pkg::BIT_IDX_W;
  localparam int CW  = bfa_pkg::COUNT_W;

  bfa_pkg::state_t                state;
  bfa_pkg::state_t                state_next;
  logic [CW-1:0]                  frame_count;
  logic [CW-1:0]                  frame_limit;
  logic [CW-1:0]                  frame_limit_in;
  logic [1:0]                     op;
  logic [bfa_pkg::FRAME_W-1:0]    frame;
  logic [WIW-1:0]                 word_addr;
  logic [WIW-1:0]                 word_addr_next;
  bfa_pkg::rsp_t                  res;
  bfa_pkg::rsp_t                  res_next;
  bfa_pkg::map_wr_t               map_wr;
  logic [bfa_pkg::WORD_BITS-1:0]  map_word;
  logic [bfa_pkg::WORD_BITS-1:0]  word_mask;
  logic [bfa_pkg::WORD_BITS-1:0]  masked;
  logic [BIW-1:0]                 hit_bit;
  logic                           hit;
  logic                           last_word;
  logic [CW-1:0]                  next_start;
  logic                           req_beat;
  logic                           rsp_load;
  logic                           cfg_write;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == bfa_pkg::REG_FRAME_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= bfa_pkg::FRAME_COUNT_RESET;
    end else if (cfg_write) begin
      frame_count <= pwdata[CW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bfa_pkg::REG_FRAME_COUNT) begin
      prdata = bfa_pkg::PDATA_W'(frame_count);
    end
  end

  // Map memory
  bfa_map u_map (
    .clk   (clk),
    .rst   (rst),
    .raddr (word_addr_next),
    .rdata (map_word),
    .wr    (map_wr)
  );

  assign frame_limit_in = (frame_count > bfa_pkg::FRAME_LIMIT_MAX) ?
                          bfa_pkg::FRAME_LIMIT_MAX : frame_count;

  assign req_ready = (state == bfa_pkg::S_IDLE);
  assign req_beat  = req_valid && req_ready;
  assign rsp_load  = (state == bfa_pkg::S_DONE) && (!rsp_valid || rsp_ready);

  // Scan datapath
  always_comb begin
    if ({1'b0, word_addr} < frame_limit[CW-1:BIW]) begin
      word_mask = '1;
    end else if ({1'b0, word_addr} == frame_limit[CW-1:BIW]) begin
      word_mask = ~({bfa_pkg::WORD_BITS{1'b1}} << frame_limit[BIW-1:0]);
    end else begin
      word_mask = '0;
    end
  end

  assign masked     = map_word & word_mask;
  assign hit        = |masked;
  assign hit_bit    = bfa_pkg::lowest_set(masked);
  assign next_start = {(WIW+1)'({1'b0, word_addr}) + (WIW+1)'(1), {BIW{1'b0}}};
  assign last_word  = next_start >= frame_limit;

  always_comb begin
    state_next     = state;
    word_addr_next = word_addr;
    res_next       = res;
    map_wr         = '0;
    unique case (state)
      bfa_pkg::S_IDLE: begin
        if (req_valid) begin
          res_next.frame_number_out = req.frame_number;
          res_next.status           = bfa_pkg::STATUS_DONE;
          if (req.operation == bfa_pkg::OP_ALLOC) begin
            word_addr_next = '0;
            if (frame_limit_in == '0) begin
              res_next.frame_number_out = '0;
              res_next.status           = bfa_pkg::STATUS_NONE_FREE;
              state_next                = bfa_pkg::S_DONE;
            end else begin
              state_next = bfa_pkg::S_SCAN;
            end
          end else if ((req.operation != bfa_pkg::OP_FREE &&
                        req.operation != bfa_pkg::OP_RESERVE) ||
                       ({1'b0, req.frame_number} >= frame_limit_in)) begin
            res_next.status = bfa_pkg::STATUS_RANGE;
            state_next      = bfa_pkg::S_DONE;
          end else begin
            word_addr_next = req.frame_number[bfa_pkg::FRAME_W-1:BIW];
            state_next     = bfa_pkg::S_MODIFY;
          end
        end
      end
      bfa_pkg::S_SCAN: begin
        if (hit) begin
          map_wr.en                 = 1'b1;
          map_wr.addr               = word_addr;
          map_wr.data               = map_word & ~(bfa_pkg::WORD_BITS'(1) << hit_bit);
          res_next.frame_number_out = {word_addr, hit_bit};
          res_next.status           = bfa_pkg::STATUS_DONE;
          state_next                = bfa_pkg::S_DONE;
        end else if (last_word) begin
          res_next.frame_number_out = '0;
          res_next.status           = bfa_pkg::STATUS_NONE_FREE;
          state_next                = bfa_pkg::S_DONE;
        end else begin
          word_addr_next = word_addr + WIW'(1);
        end
      end
      bfa_pkg::S_MODIFY: begin
        map_wr.en   = 1'b1;
        map_wr.addr = word_addr;
        if (op == bfa_pkg::OP_FREE) begin
          map_wr.data = map_word | (bfa_pkg::WORD_BITS'(1) << frame[BIW-1:0]);
        end else begin
          map_wr.data = map_word & ~(bfa_pkg::WORD_BITS'(1) << frame[BIW-1:0]);
        end
        state_next = bfa_pkg::S_DONE;
      end
      bfa_pkg::S_DONE: begin
        if (rsp_load) begin
          state_next = bfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bfa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    word_addr <= word_addr_next;
    res       <= res_next;
    if (req_beat) begin
      op          <= req.operation;
      frame       <= req.frame_number;
      frame_limit <= frame_limit_in;
    end
    if (rsp_load) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  a_scan_in_limit: assert property (@(posedge clk) disable iff (rst)
    state == bfa_pkg::S_SCAN |-> {1'b0, word_addr, {BIW{1'b0}}} < frame_limit)
    else $error("scan word beyond active limit");

  a_hit_in_limit: assert property (@(posedge clk) disable iff (rst)
    state == bfa_pkg::S_SCAN && hit |-> {1'b0, word_addr, hit_bit} < frame_limit)
    else $error("allocated frame beyond active limit");

  a_write_only_when_modifying: assert property (@(posedge clk) disable iff (rst)
    map_wr.en |-> state == bfa_pkg::S_SCAN || state == bfa_pkg::S_MODIFY)
    else $error("map write outside scan or modify");

  a_done_loads_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> rsp_valid && state == bfa_pkg::S_IDLE)
    else $error("result not presented after completion");

  a_no_req_while_busy: assert property (@(posedge clk) disable iff (rst)
    state != bfa_pkg::S_IDLE |-> !req_ready)
    else $error("request taken while busy");

endmodule
